### hdl/rv32i_pkg.sv
// Package for the RV32I execute unit: opcodes, function codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package rv32i_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] SP_RESET = 32'h0000_3ffc;
  localparam logic [31:0] GP_RESET = 32'h0000_1800;
  localparam logic [31:0] EXIT_CALL = 32'd10;
  localparam logic [4:0]  REG_A7 = 5'd17;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Input beat payload.
  typedef struct packed {
    logic        mode;
    logic [31:0] instruction;
    logic [11:0] preload_index;
    logic [31:0] preload_word;
  } in_beat_t;

  // Result beat payload.
  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        halted;
  } out_beat_t;

  // Load held between the memory read and its write-back.
  typedef struct packed {
    logic        active;
    logic [2:0]  funct3;
    logic [1:0]  lane;
    logic [4:0]  rd;
    logic [31:0] next_pc;
  } load_ctl_t;

endpackage

### hdl/rv32i_if.sv
// Valid/ready channel interface carrying one payload beat.
// Depends on rv32i_pkg for the payload types.
`timescale 1ns / 1ps
interface rv32i_in_if;
  import rv32i_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rv32i_out_if;
  import rv32i_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/rv32i_instruction_execute_unit.sv
// RV32I execute unit: single-pass decode, ALU and data memory with a result register.
// Depends on rv32i_pkg and the channel interfaces in rv32i_if.sv.
// An instruction is decoded and executed in the cycle its beat is accepted. Its result beat
// is presented from the result register on the next cycle, so beats may follow back to back.
// A result beat that is not taken holds off the input until it leaves. A load reads the
// synchronous data memory port in its accept cycle and writes back in the next cycle, during
// which no beat is accepted. After reset a clearing pass zeroes every word of the data memory,
// and no beat is accepted until it ends. MEM_WORDS must be a power of two; byte addresses wrap
// modulo 4*MEM_WORDS and preload indexes wrap modulo MEM_WORDS.
`timescale 1ns / 1ps
module rv32i_instruction_execute_unit
  import rv32i_pkg::*;
#(
  parameter int MEM_WORDS = 4096
) (
  input logic clk,
  input logic rst_n,
  rv32i_in_if.sink    in_ch,
  rv32i_out_if.source out_ch
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] regs_r [32];
  logic [31:0] pc_r;
  logic        halt_r;
  logic [AW:0] clr_r;
  logic        clearing;
  out_beat_t   out_r;
  logic        out_v_r;
  load_ctl_t   ld_r;
  logic [31:0] rdata_r;

  assign clearing = !clr_r[AW];
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // Accept when out of reset and clearing, the result slot frees up and no load is finishing.
  logic in_fire, out_free;
  assign out_free = !out_v_r || out_ch.ready;
  assign in_ch.ready = rst_n && !clearing && !ld_r.active && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Decode.
  in_beat_t d;
  logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_j, imm_u, c, addr;
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic [4:0] rd, sh;
  assign d = in_ch.data;
  assign ins = d.instruction;
  assign op = ins[6:0];
  assign f3 = ins[14:12];
  assign f7 = ins[31:25];
  assign rd = ins[11:7];
  assign a = (ins[19:15] == 5'd0) ? 32'd0 : regs_r[ins[19:15]];
  assign b = (ins[24:20] == 5'd0) ? 32'd0 : regs_r[ins[24:20]];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'd0};
  assign c = (op == OP_REG) ? b : imm_i;
  assign sh = c[4:0];
  assign addr = a + ((op == OP_STORE) ? imm_s : imm_i);

  // Execute.
  logic        wr, take, is_load, is_store, do_halt;
  logic [31:0] wval, npc, pc4;
  logic [31:0] st_w;
  logic [3:0]  st_be;
  assign pc4 = pc_r + 32'd4;
  always_comb begin
    wr = 1'b0; wval = 32'd0; npc = pc4; take = 1'b0;
    is_load = 1'b0; is_store = 1'b0; do_halt = 1'b0;
    st_w = b; st_be = 4'd0;
    unique case (op)
      OP_LUI:   begin wr = 1'b1; wval = imm_u; end
      OP_AUIPC: begin wr = 1'b1; wval = pc_r + imm_u; end
      OP_JAL:   begin wr = 1'b1; wval = pc4; npc = pc_r + imm_j; end
      OP_JALR:  begin wr = 1'b1; wval = pc4; npc = (a + imm_i) & ~32'd1; end
      OP_BRANCH: begin
        unique case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = $signed(a) >= $signed(b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: take = 1'b0;
        endcase
        if (take) npc = pc_r + imm_b;
      end
      OP_LOAD: is_load = (f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd2) ||
                         (f3 == 3'd4) || (f3 == 3'd5);
      OP_STORE: begin
        unique case (f3)
          3'd0: begin st_w = {4{b[7:0]}}; st_be = 4'b0001 << addr[1:0]; end
          3'd1: begin st_w = {2{b[15:0]}}; st_be = addr[1] ? 4'b1100 : 4'b0011; end
          3'd2: st_be = 4'b1111;
          default: st_be = 4'd0;
        endcase
        is_store = st_be != 4'd0;
      end
      OP_IMM, OP_REG: begin
        wr = 1'b1;
        unique case (f3)
          3'd0: begin
            if (op == OP_IMM || f7 == F7_ZERO) wval = a + c;
            else if (f7 == F7_ALT) wval = a - c;
            else wr = 1'b0;
          end
          3'd1: begin
            if (op == OP_REG || f7 == F7_ZERO) wval = a << sh;
            else wr = 1'b0;
          end
          3'd2: wval = {31'd0, $signed(a) < $signed(c)};
          3'd3: wval = {31'd0, a < c};
          3'd4: wval = a ^ c;
          3'd5: begin
            if (f7 == F7_ZERO) wval = a >> sh;
            else if (f7 == F7_ALT) wval = 32'($signed(a) >>> sh);
            else wr = 1'b0;
          end
          3'd6: wval = a | c;
          default: wval = a & c;
        endcase
      end
      OP_SYSTEM: begin
        if (regs_r[REG_A7] == EXIT_CALL) begin do_halt = 1'b1; npc = pc_r; end
      end
      default: ;
    endcase
  end

  logic exec, ld_start, wb;
  assign exec = in_fire && !d.mode && !halt_r;
  assign ld_start = exec && is_load;
  assign wb = exec && !is_load && wr && (rd != 5'd0);

  // Data memory: one write port, one registered read port.
  logic [AW-1:0] raddr;
  assign raddr = addr[AW+1:2];
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_r[AW-1:0]] <= 32'd0;
    end else if (in_fire && d.mode) begin
      mem[AW'(d.preload_index)] <= d.preload_word;
    end else if (exec && is_store) begin
      for (int i = 0; i < 4; i++) begin
        if (st_be[i]) mem[raddr][8*i +: 8] <= st_w[8*i +: 8];
      end
    end
    rdata_r <= mem[raddr];
  end

  // Load completion formatting.
  logic [31:0] ld_val, sh_w;
  always_comb begin
    sh_w = rdata_r >> {ld_r.lane, 3'd0};
    unique case (ld_r.funct3)
      3'd0: ld_val = {{24{sh_w[7]}}, sh_w[7:0]};
      3'd1: ld_val = {{16{sh_w[15]}}, sh_w[15:0]};
      3'd4: ld_val = {24'd0, sh_w[7:0]};
      3'd5: ld_val = {16'd0, sh_w[15:0]};
      default: ld_val = rdata_r;
    endcase
  end

  // Architectural state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 32'd0;
      halt_r <= 1'b0;
      clr_r <= '0;
      out_v_r <= 1'b0;
      ld_r <= '0;
      for (int i = 0; i < 32; i++) begin
        regs_r[i] <= (i == 2) ? SP_RESET : (i == 3) ? GP_RESET : 32'd0;
      end
    end else begin
      if (clearing) clr_r <= clr_r + 1'b1;
      ld_r.active <= ld_start;
      if (ld_r.active) out_v_r <= 1'b1;
      else if (in_fire) out_v_r <= !ld_start;
      else if (out_ch.ready) out_v_r <= 1'b0;
      if (ld_r.active) begin
        out_r.next_pc <= ld_r.next_pc;
        out_r.halted <= halt_r;
        out_r.reg_write <= ld_r.rd != 5'd0;
        out_r.reg_index <= ld_r.rd;
        out_r.reg_value <= (ld_r.rd != 5'd0) ? ld_val : 32'd0;
        if (ld_r.rd != 5'd0) regs_r[ld_r.rd] <= ld_val;
      end else if (in_fire) begin
        out_r.next_pc <= exec ? npc : pc_r;
        out_r.halted <= halt_r || (exec && do_halt);
        out_r.reg_write <= wb;
        out_r.reg_index <= wb ? rd : 5'd0;
        out_r.reg_value <= wb ? wval : 32'd0;
        if (exec) pc_r <= npc;
        if (exec && do_halt) halt_r <= 1'b1;
        if (wb) regs_r[rd] <= wval;
        if (ld_start) begin
          ld_r.funct3 <= f3;
          ld_r.lane <= (f3[1:0] == 2'd1) ? {addr[1], 1'b0} : addr[1:0];
          ld_r.rd <= rd;
          ld_r.next_pc <= npc;
        end
      end
    end
  end

endmodule
